FILE: sv/tlfa_pkg.sv
`default_nettype none

package tlfa_pkg;

    localparam int unsigned COORD_W  = 10;
    localparam int unsigned OFFSET_W = 18;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

    localparam logic [COORD_W-1:0] SCREEN_W_RESET = 10'd240;
    localparam logic [COORD_W-1:0] SCREEN_H_RESET = 10'd240;

    localparam logic [7:0] NARROW_MAX  = 8'd126;
    localparam logic [7:0] ASCII_FIRST = 8'd32;
    localparam logic [7:0] LEAD_FIRST  = 8'hB0;
    localparam logic [7:0] LEAD_LAST   = 8'hF7;
    localparam logic [7:0] TRAIL_FIRST = 8'hA1;
    localparam logic [7:0] TRAIL_LAST  = 8'hFE;

    localparam logic [12:0] ROW_CODES = 13'd94;

    localparam logic [COORD_W:0] NARROW_W = 11'd8;
    localparam logic [COORD_W:0] WIDE_W   = 11'd16;
    localparam logic [COORD_W:0] GLYPH_H  = 11'd16;

    typedef struct packed {
        logic [COORD_W-1:0]  char_x;
        logic [COORD_W-1:0]  char_y;
        logic                wide_char;
        logic [OFFSET_W-1:0] font_offset;
        logic                code_ok;
    } tlfa_result_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic                ok;
    } tlfa_glyph_t;

endpackage

`default_nettype wire

FILE: sv/tlfa_glyph.sv
`default_nettype none

// Font store addressing for one character: narrow ASCII or wide two-byte code.
module tlfa_glyph
    import tlfa_pkg::*;
(
    input  wire logic [7:0]  code_byte,
    input  wire logic [7:0]  lead_byte,
    input  wire logic        is_wide,
    output tlfa_glyph_t      glyph
);

    logic [7:0]  row_diff;
    logic [7:0]  col_diff;
    logic [7:0]  asc_diff;
    logic [12:0] row_base;
    logic [12:0] wide_index;
    logic        wide_ok;
    logic        narrow_ok;

    assign row_diff = lead_byte - LEAD_FIRST;
    assign col_diff = code_byte - TRAIL_FIRST;
    assign asc_diff = code_byte - ASCII_FIRST;

    assign row_base   = 13'(row_diff[6:0]) * ROW_CODES;
    assign wide_index = row_base + 13'(col_diff[6:0]);

    assign wide_ok = (lead_byte >= LEAD_FIRST) && (lead_byte <= LEAD_LAST)
                  && (code_byte >= TRAIL_FIRST) && (code_byte <= TRAIL_LAST);
    assign narrow_ok = (code_byte >= ASCII_FIRST);

    always_comb
    begin
        glyph.ok     = 1'b0;
        glyph.offset = '0;
        if (is_wide)
        begin
            if (wide_ok)
            begin
                glyph.ok     = 1'b1;
                glyph.offset = {wide_index, 5'd0};
            end
        end
        else if (narrow_ok)
        begin
            glyph.ok     = 1'b1;
            glyph.offset = OFFSET_W'({asc_diff[6:0], 4'd0});
        end
    end

endmodule

`default_nettype wire

FILE: sv/text_layout_font_addresser_core.sv
`default_nettype none

// Channel   Direction  Handshake               Contents
// in        input      in_valid / in_ready     text_byte, first_of_string, last_of_string,
//                                              start_x, start_y
// out       output     out_valid / out_ready   char_x, char_y, wide_char, font_offset, code_ok
// cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One byte per cycle while in_ready is high: each accepted byte that completes a character
// is placed, addressed and written to the output stage in the cycle it is accepted.
// A two-entry output stage (result register plus skid register) keeps in_ready
// independent of out_ready; input stalls only when both entries are full.
// Reset clears the cursor, the pending lead byte and the output stage, and loads
// both screen dimensions with 240. The configuration port is always ready.
module text_layout_font_addresser_core
    import tlfa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           text_byte,
    input  wire logic                 first_of_string,
    input  wire logic                 last_of_string,
    input  wire logic [COORD_W-1:0]   start_x,
    input  wire logic [COORD_W-1:0]   start_y,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [COORD_W-1:0]        char_x,
    output logic [COORD_W-1:0]        char_y,
    output logic                      wide_char,
    output logic [OFFSET_W-1:0]       font_offset,
    output logic                      code_ok,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COORD_W-1:0]   cfg_data
);

    logic [COORD_W-1:0] screen_w_reg;
    logic [COORD_W-1:0] screen_h_reg;
    logic [COORD_W-1:0] cursor_x_reg;
    logic [COORD_W-1:0] cursor_y_reg;
    logic [COORD_W-1:0] cursor_x_next;
    logic [COORD_W-1:0] cursor_y_next;
    logic [7:0]         lead_byte_reg;
    logic               lead_pending_reg;

    tlfa_result_t       main_reg;
    tlfa_result_t       skid_reg;
    logic               main_valid_reg;
    logic               skid_valid_reg;
    tlfa_result_t       result_next;

    logic               in_fire;
    logic               out_fire;
    logic               pending;
    logic               is_narrow;
    logic               is_lead;
    logic               has_result;
    logic               push;
    logic [COORD_W-1:0] eff_x;
    logic [COORD_W-1:0] eff_y;
    logic [COORD_W:0]   glyph_w;
    logic [COORD_W:0]   x_sum;
    logic               line_wrap;
    logic [COORD_W:0]   x_line;
    logic [COORD_W:0]   y_line;
    logic [COORD_W+1:0] y_bottom;
    logic               page_wrap;
    logic [COORD_W:0]   place_x;
    logic [COORD_W:0]   place_y;
    logic [COORD_W:0]   x_adv;
    tlfa_glyph_t        glyph;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = main_valid_reg && out_ready;

    // A byte that starts a string discards any held lead byte.
    assign pending    = lead_pending_reg && !first_of_string;
    assign is_narrow  = !pending && (text_byte <= NARROW_MAX);
    assign is_lead    = !pending && (text_byte > NARROW_MAX);
    assign has_result = pending || is_narrow;
    assign push       = in_fire && has_result;

    assign eff_x = first_of_string ? start_x : cursor_x_reg;
    assign eff_y = first_of_string ? start_y : cursor_y_reg;

    assign glyph_w   = pending ? WIDE_W : NARROW_W;
    assign x_sum     = {1'b0, eff_x} + glyph_w;
    assign line_wrap = x_sum > {1'b0, screen_w_reg};
    assign x_line    = line_wrap ? '0 : {1'b0, eff_x};
    assign y_line    = line_wrap ? ({1'b0, eff_y} + GLYPH_H) : {1'b0, eff_y};
    assign y_bottom  = {1'b0, y_line} + {1'b0, GLYPH_H};
    assign page_wrap = y_bottom > {2'b00, screen_h_reg};
    assign place_x   = page_wrap ? '0 : x_line;
    assign place_y   = page_wrap ? '0 : y_line;
    assign x_adv     = place_x + glyph_w;

    tlfa_glyph u_glyph (
        .code_byte (text_byte),
        .lead_byte (lead_byte_reg),
        .is_wide   (pending),
        .glyph     (glyph)
    );

    always_comb
    begin
        result_next.char_x      = place_x[COORD_W-1:0];
        result_next.char_y      = place_y[COORD_W-1:0];
        result_next.wide_char   = pending;
        result_next.font_offset = glyph.offset;
        result_next.code_ok     = glyph.ok;
    end

    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        if (in_fire)
        begin
            if (has_result)
            begin
                cursor_x_next = x_adv[COORD_W-1:0];
                cursor_y_next = place_y[COORD_W-1:0];
            end
            else if (first_of_string)
            begin
                cursor_x_next = start_x;
                cursor_y_next = start_y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_w_reg <= SCREEN_W_RESET;
            screen_h_reg <= SCREEN_H_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  screen_w_reg <= cfg_data;
                REG_SCREEN_HEIGHT: screen_h_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            lead_byte_reg    <= '0;
            lead_pending_reg <= 1'b0;
        end
        else
        begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            if (in_fire)
            begin
                // A lead byte that ends the string is dropped.
                lead_pending_reg <= is_lead && !last_of_string;
                if (is_lead && !last_of_string)
                begin
                    lead_byte_reg <= text_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_fire || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= push;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
                if (push)
                begin
                    skid_reg <= result_next;
                end
            end
            else if (push)
            begin
                main_reg <= result_next;
            end
        end
        else if (push)
        begin
            skid_reg <= result_next;
        end
    end

    assign out_valid   = main_valid_reg;
    assign char_x      = main_reg.char_x;
    assign char_y      = main_reg.char_y;
    assign wide_char   = main_reg.wide_char;
    assign font_offset = main_reg.font_offset;
    assign code_ok     = main_reg.code_ok;

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held while result register is empty");

    a_trail_clears_lead: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && lead_pending_reg && !first_of_string) |=> !lead_pending_reg)
        else $error("lead byte still pending after its trail byte");

    a_bad_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !code_ok) |-> (font_offset == '0))
        else $error("out-of-font code carries a nonzero offset");

    a_wide_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && wide_char) |-> (font_offset[4:0] == 5'd0))
        else $error("wide glyph offset not on a 32-byte boundary");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (main_valid_reg && skid_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("held result lost while output stalled");

endmodule

`default_nettype wire
